### rtl/lcmtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmtd_pkg
// Shared types, constants and the microcode ROM of the trial-division LCM.
// ----------------------------------------------------------------------------
package lcmtd_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RESULT_WIDTH  = 32;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH + 1);
  localparam int PC_WIDTH      = 4;

  typedef logic [PC_WIDTH-1:0] pc_t;

  // Datapath operation carried by each control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_APPLY,
    OP_INC_D,
    OP_XY,
    OP_MUL_T,
    OP_CLR,
    OP_EMIT
  } op_t;

  // Jump condition; when it holds the step counter loads the target.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_ZERO,
    C_SQ_DONE,
    C_DIV_BUSY,
    C_DIV_HIT,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Divider lane status.
  typedef struct packed {
    logic                     busy;
    logic [OPERAND_WIDTH-1:0] quo;
    logic [OPERAND_WIDTH-1:0] rem;
  } div_res_t;

  localparam pc_t S_IDLE = pc_t'(0);
  localparam pc_t S_ZCHK = pc_t'(1);
  localparam pc_t S_TEST = pc_t'(2);
  localparam pc_t S_DIV  = pc_t'(3);
  localparam pc_t S_WAIT = pc_t'(4);
  localparam pc_t S_APPL = pc_t'(5);
  localparam pc_t S_INC  = pc_t'(6);
  localparam pc_t S_FIN  = pc_t'(7);
  localparam pc_t S_MUL  = pc_t'(8);
  localparam pc_t S_ZERO = pc_t'(9);
  localparam pc_t S_OUT  = pc_t'(10);
  localparam pc_t S_BACK = pc_t'(11);

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    case (pc)
      S_IDLE: w = '{op: OP_LOAD,      cond: C_NO_IN,    target: S_IDLE};
      S_ZCHK: w = '{op: OP_NOP,       cond: C_ZERO,     target: S_ZERO};
      S_TEST: w = '{op: OP_NOP,       cond: C_SQ_DONE,  target: S_FIN};
      S_DIV:  w = '{op: OP_DIV_START, cond: C_NEVER,    target: S_IDLE};
      S_WAIT: w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: S_WAIT};
      S_APPL: w = '{op: OP_APPLY,     cond: C_DIV_HIT,  target: S_DIV};
      S_INC:  w = '{op: OP_INC_D,     cond: C_ALWAYS,   target: S_TEST};
      S_FIN:  w = '{op: OP_XY,        cond: C_NEVER,    target: S_IDLE};
      S_MUL:  w = '{op: OP_MUL_T,     cond: C_ALWAYS,   target: S_OUT};
      S_ZERO: w = '{op: OP_CLR,       cond: C_NEVER,    target: S_IDLE};
      S_OUT:  w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: S_OUT};
      S_BACK: w = '{op: OP_NOP,       cond: C_ALWAYS,   target: S_IDLE};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/lcmtd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmtd_div
// Restoring divider, one quotient bit per cycle, for one remainder lane.
// ----------------------------------------------------------------------------
module lcmtd_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [lcmtd_pkg::OPERAND_WIDTH-1:0] dividend,
  input  logic [lcmtd_pkg::OPERAND_WIDTH-1:0] divisor,
  output lcmtd_pkg::div_res_t                 res
);

  localparam int W = lcmtd_pkg::OPERAND_WIDTH;

  logic [W:0]                          rem_r, rem_nxt;
  logic [W-1:0]                        quo_r, quo_nxt;
  logic [W-1:0]                        dvs_r, dvs_nxt;
  logic [lcmtd_pkg::CNT_WIDTH-1:0]     cnt_r, cnt_nxt;
  logic [W:0]                          trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r[W-1:0], quo_r[W-1]};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = lcmtd_pkg::CNT_WIDTH'(W);
    end else if (cnt_r != '0) begin
      // Shift the next dividend bit in and subtract when it fits.
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.busy = (cnt_r != '0);
  assign res.quo  = quo_r;
  assign res.rem  = rem_r[W-1:0];

endmodule

### rtl/lcm_trial_division_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_trial_division_top
// Least common multiple of two operands by trial division, microcoded.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid/in_ready) carries two operands.
//   The block answers each request with one lcm_value on the output channel
//   (out_valid/out_ready). If either operand is zero the result is zero.
//   in_ready is high only while the step counter sits at its idle step, so
//   one request is worked on at a time.
//   Latency depends on the data. Each trial divisor costs a test step, then
//   one pass of the bit-serial dividers plus three control steps per
//   division. The divisor runs up to the square root of the larger
//   remainder, at most about 256 divisors; a zero operand goes straight to
//   the result without any trial division.
//   The result sits in an output register. A stalled receiver does not block
//   the next request: the block only waits at its last step when a new result
//   is ready while the previous one has not yet been taken.
//   Reset (rst_n low, synchronous) returns the step counter to idle and
//   drops out_valid; no memory needs clearing.
// ----------------------------------------------------------------------------
module lcm_trial_division_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_first_value,
  input  logic [15:0] in_second_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_lcm_value
);

  localparam int W  = lcmtd_pkg::OPERAND_WIDTH;
  localparam int RW = lcmtd_pkg::RESULT_WIDTH;
  localparam int PW = lcmtd_pkg::PROD_WIDTH;

  lcmtd_pkg::pc_t      pc_r, pc_nxt;
  lcmtd_pkg::uword_t   uw;
  logic                cond_ok;

  logic [W-1:0]        x_r, x_nxt;
  logic [W-1:0]        y_r, y_nxt;
  logic [W-1:0]        d_r, d_nxt;
  logic [RW-1:0]       prod_r, prod_nxt;
  logic [PW-1:0]       t_r, t_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RW-1:0]       out_r, out_nxt;

  logic                div_start;
  lcmtd_pkg::div_res_t div_x, div_y;
  logic [PW-1:0]       d_sq;
  logic                hit_x, hit_y;
  logic                out_busy;

  lcmtd_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(x_r),
    .divisor (d_r),
    .res     (div_x)
  );

  lcmtd_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(y_r),
    .divisor (d_r),
    .res     (div_y)
  );

  assign uw        = lcmtd_pkg::ucode(pc_r);
  assign d_sq      = d_r * d_r;
  assign hit_x     = (div_x.rem == '0);
  assign hit_y     = (div_y.rem == '0);
  assign out_busy  = out_valid_r && !out_ready;
  assign div_start = (uw.op == lcmtd_pkg::OP_DIV_START);

  always_comb begin
    case (uw.cond)
      lcmtd_pkg::C_NEVER:    cond_ok = 1'b0;
      lcmtd_pkg::C_ALWAYS:   cond_ok = 1'b1;
      lcmtd_pkg::C_NO_IN:    cond_ok = !in_valid;
      lcmtd_pkg::C_ZERO:     cond_ok = (x_r == '0) || (y_r == '0);
      lcmtd_pkg::C_SQ_DONE:  cond_ok = (d_sq > PW'(x_r)) && (d_sq > PW'(y_r));
      lcmtd_pkg::C_DIV_BUSY: cond_ok = div_x.busy || div_y.busy;
      lcmtd_pkg::C_DIV_HIT:  cond_ok = hit_x || hit_y;
      lcmtd_pkg::C_OUT_BUSY: cond_ok = out_busy;
      default:               cond_ok = 1'b0;
    endcase
    pc_nxt = cond_ok ? uw.target : pc_r + 1'b1;
  end

  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (uw.op)
      lcmtd_pkg::OP_LOAD: begin
        if (in_valid) begin
          x_nxt    = in_first_value[W-1:0];
          y_nxt    = in_second_value[W-1:0];
          d_nxt    = W'(2);
          prod_nxt = RW'(1);
        end
      end
      lcmtd_pkg::OP_APPLY: begin
        // Divide every remainder the divisor goes into; one factor per round.
        if (hit_x) begin
          x_nxt = div_x.quo;
        end
        if (hit_y) begin
          y_nxt = div_y.quo;
        end
        if (hit_x || hit_y) begin
          prod_nxt = RW'(prod_r * d_r);
        end
      end
      lcmtd_pkg::OP_INC_D: begin
        d_nxt = d_r + 1'b1;
      end
      lcmtd_pkg::OP_XY: begin
        // Leftover remainders are 1 or primes; count a shared prime once.
        t_nxt = (x_r == y_r) ? PW'(x_r) : x_r * y_r;
      end
      lcmtd_pkg::OP_MUL_T: begin
        prod_nxt = RW'(prod_r * t_r);
      end
      lcmtd_pkg::OP_CLR: begin
        prod_nxt = '0;
      end
      lcmtd_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_nxt       = prod_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= lcmtd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready      = (pc_r == lcmtd_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_lcm_value = out_r;

endmodule
